FILE: rtl/matrix_symmetry_diagonal_check_macros.svh
// Assertion macros shared by the matrix symmetry and diagonal check RTL.
`ifndef MATRIX_SYMMETRY_DIAGONAL_CHECK_MACROS_SVH
`define MATRIX_SYMMETRY_DIAGONAL_CHECK_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MSDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MSDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/msdc_pkg.sv
// Types shared by the matrix symmetry and diagonal check block.
package msdc_pkg;

	localparam int ElementWidth = 32;
	localparam int SizeWidth = 7;

	typedef logic signed [ElementWidth-1:0] element_t;
	typedef logic [SizeWidth-1:0] size_t;

	typedef struct packed {
		logic     check_mirror;
		logic     off_diag_nonzero;
		logic     last;
		element_t value;
	} stage_t;

endpackage

FILE: rtl/msdc_stream_if.sv
// Stream interfaces for element beats and result beats.
interface msdc_elem_if import msdc_pkg::*; ();
	logic     valid;
	logic     ready;
	element_t element_value;

	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

interface msdc_result_if import msdc_pkg::*; ();
	logic valid;
	logic ready;
	logic is_symmetric;
	logic is_diagonal;

	modport source (output valid, output is_symmetric, output is_diagonal, input ready);
	modport sink (input valid, input is_symmetric, input is_diagonal, output ready);
endinterface

FILE: rtl/msdc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module msdc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/matrix_symmetry_diagonal_check.sv
// Top level of the matrix symmetry and diagonal check block.
// Throughput is one element beat per cycle unless stalled, set by the store's single read and write port.
// The result beat is registered after the last element of a matrix passes stage one.
// The element store has no reset and needs no clearing pass; elements are accepted right after reset.
// Reset sets the matrix size to one, both positions to zero and both flags to one.
`include "matrix_symmetry_diagonal_check_macros.svh"

module matrix_symmetry_diagonal_check import msdc_pkg::*; #(
	parameter int MAX_SIZE = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  size_t         cfg_wdata,
	msdc_elem_if.sink     elem,
	msdc_result_if.source result
);

	localparam int PW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int SW = $clog2(MAX_SIZE + 1);
	localparam int CW = (SW > SizeWidth) ? SW : SizeWidth;
	localparam int DEPTH = 1 << (2 * PW);

	size_t          size_q;
	logic [PW-1:0]  row_q;
	logic [PW-1:0]  col_q;
	logic           sym_q;
	logic           diag_q;
	logic           valid_s1;
	stage_t         stage_s1;
	logic           out_valid_q;
	logic           out_sym_q;
	logic           out_diag_q;

	logic [CW-1:0]  size_ext;
	logic [CW-1:0]  eff_size;
	logic           last_col;
	logic           last_row;
	logic           accept;
	logic           stall;
	logic           fire_s1;
	logic           sym_next;
	logic           diag_next;
	element_t       mirror_value;
	stage_t         stage_in;

	always_comb begin
		size_ext = CW'(size_q);
		if (size_ext == '0) begin
			eff_size = CW'(1);
		end else if (size_ext > CW'(MAX_SIZE)) begin
			eff_size = CW'(MAX_SIZE);
		end else begin
			eff_size = size_ext;
		end
	end

	assign last_col = (CW'(col_q) == eff_size - CW'(1));
	assign last_row = (CW'(row_q) == eff_size - CW'(1));

	// The last element of a matrix waits in stage one while the result register is still full.
	assign stall = valid_s1 && stage_s1.last && out_valid_q && !result.ready;
	assign elem.ready = !stall;
	assign accept = elem.valid && elem.ready;
	assign fire_s1 = valid_s1 && !stall;

	always_comb begin
		stage_in.check_mirror = (row_q > col_q);
		stage_in.off_diag_nonzero = (row_q != col_q) && (elem.element_value != '0);
		stage_in.last = last_col && last_row;
		stage_in.value = elem.element_value;
	end

	// The mirror of a below-diagonal element was written at least one beat earlier.
	msdc_ram #(
		.WIDTH(ElementWidth),
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.we(accept),
		.waddr({row_q, col_q}),
		.wdata(elem.element_value),
		.re(accept),
		.raddr({col_q, row_q}),
		.rdata(mirror_value)
	);

	assign sym_next = sym_q && !(stage_s1.check_mirror && (mirror_value != stage_s1.value));
	assign diag_next = diag_q && !stage_s1.off_diag_nonzero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= size_t'(1);
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + PW'(1);
			end else begin
				col_q <= col_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && accept) begin
			stage_s1 <= stage_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= 1'b1;
			diag_q <= 1'b1;
		end else if (cfg_we || (fire_s1 && stage_s1.last)) begin
			sym_q <= 1'b1;
			diag_q <= 1'b1;
		end else if (fire_s1) begin
			sym_q <= sym_next;
			diag_q <= diag_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && stage_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && stage_s1.last) begin
			out_sym_q <= sym_next;
			out_diag_q <= diag_next;
		end
	end

	assign result.valid = out_valid_q;
	assign result.is_symmetric = out_sym_q;
	assign result.is_diagonal = out_diag_q;

	`MSDC_ASSERT_NOW(a_pos_in_range, 1'b1, (CW'(row_q) < eff_size) && (CW'(col_q) < eff_size), "Matrix position outside the matrix.")
	`MSDC_ASSERT_NEXT(a_flags_restart, fire_s1 && stage_s1.last, sym_q && diag_q, "Flags not restarted after the last element.")
	`MSDC_ASSERT_NOW(a_result_source, $rose(out_valid_q), $past(valid_s1 && stage_s1.last), "Result beat without a last element.")

endmodule

FILE: tb/sv/msdc_flag_checker.sv
// Checker that predicts the symmetry and diagonal flags of each matrix and compares result beats.
module msdc_flag_checker import msdc_pkg::*; #(
	parameter int MAX_SIZE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  size_t       cfg_wdata,
	msdc_elem_if        elem,
	msdc_result_if      result,
	output int unsigned fail_count,
	output int unsigned outstanding,
	output int unsigned verdicts_seen
);

	typedef struct packed {
		logic symmetric;
		logic diagonal;
	} verdict_t;

	verdict_t verdict_q[$];
	element_t seen_elems [MAX_SIZE*MAX_SIZE];
	size_t    size_reg;
	int       row_at;
	int       col_at;
	logic     mirror_ok;
	logic     offdiag_zero;

	function automatic int active_size();
		if (size_reg == 0) begin
			return 1;
		end
		if (size_reg > MAX_SIZE) begin
			return MAX_SIZE;
		end
		return int'(size_reg);
	endfunction

	function automatic void clear_matrix();
		row_at = 0;
		col_at = 0;
		mirror_ok = 1'b1;
		offdiag_zero = 1'b1;
	endfunction

	task automatic absorb_element(input element_t value);
		int n;
		verdict_t done;
		n = active_size();
		if (row_at >= n || col_at >= n) begin
			clear_matrix();
		end
		seen_elems[row_at*MAX_SIZE + col_at] = value;
		if (row_at != col_at && value != 0) begin
			offdiag_zero = 1'b0;
		end
		// The mirror above the diagonal always arrived earlier in the same matrix.
		if (row_at > col_at && seen_elems[col_at*MAX_SIZE + row_at] != value) begin
			mirror_ok = 1'b0;
		end
		col_at++;
		if (col_at >= n) begin
			col_at = 0;
			row_at++;
		end
		if (row_at >= n) begin
			done.symmetric = mirror_ok;
			done.diagonal = offdiag_zero;
			verdict_q.push_back(done);
			clear_matrix();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			size_reg = size_t'(1);
			clear_matrix();
			verdict_q.delete();
		end else begin
			if (cfg_we) begin
				size_reg = cfg_wdata;
				clear_matrix();
			end
			if (result.valid && result.ready) begin
				verdicts_seen++;
				if (verdict_q.size() == 0) begin
					fail_count++;
					$display({"%0t: unexpected result beat, expected none, ",
						"actual symmetric %0b diagonal %0b"},
						$time, result.is_symmetric, result.is_diagonal);
				end else begin
					want = verdict_q.pop_front();
					if (result.is_symmetric !== want.symmetric) begin
						fail_count++;
						$display("%0t: is_symmetric mismatch, expected %0b actual %0b",
							$time, want.symmetric, result.is_symmetric);
					end
					if (result.is_diagonal !== want.diagonal) begin
						fail_count++;
						$display("%0t: is_diagonal mismatch, expected %0b actual %0b",
							$time, want.diagonal, result.is_diagonal);
					end
				end
			end
			if (elem.valid && elem.ready) begin
				absorb_element(elem.element_value);
			end
		end
		outstanding = verdict_q.size();
	end

endmodule

FILE: tb/sv/matrix_symmetry_diagonal_check_tb.sv
// Testbench top that streams matrices into the symmetry and diagonal check and gives the verdict.
module matrix_symmetry_diagonal_check_tb import msdc_pkg::*; ();

	localparam int MaxSize = 64;
	localparam int Period = 4;
	localparam int ResetCycles = 7;
	localparam int RandomItems = 1900;
	localparam int HoldCycles = 300;
	localparam int PressureItems = 80;
	localparam int SettleCycles = 4;
	localparam int DrainCycles = 10;
	localparam int TimeLimit = 2000000;

	typedef enum int {
		FILL_RANDOM,
		FILL_SYMMETRIC,
		FILL_DIAGONAL,
		FILL_SYM_FLAW,
		FILL_DIAG_FLAW,
		FILL_CONSTANT
	} fill_e;

	typedef enum int {
		RX_ALWAYS,
		RX_HALF,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_e;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	size_t       cfg_wdata;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned verdicts_seen;
	element_t    mat [MaxSize][MaxSize];
	int          burst_left;
	bit          hold_pending = 1'b0;
	int          beat_total;
	int          matrix_total;
	int          setting_total;

	msdc_elem_if   elem_ch ();
	msdc_result_if result_ch ();

	matrix_symmetry_diagonal_check #(.MAX_SIZE(MaxSize)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.elem     (elem_ch),
		.result   (result_ch)
	);

	msdc_flag_checker #(.MAX_SIZE(MaxSize)) flag_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.elem         (elem_ch),
		.result       (result_ch),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.verdicts_seen(verdicts_seen)
	);

	initial begin
		clk = 1'b0;
		forever #(Period/2) clk = ~clk;
	end

	initial begin
		#TimeLimit;
		$display("FAIL");
		$finish;
	end

	function automatic element_t rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 6) - 3;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'hffff_ffff;
					default: return '0;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic void fill_matrix(input int n, input fill_e fill);
		int i;
		int j;
		element_t v;
		v = rand_value();
		for (i = 0; i < n; i++) begin
			for (j = 0; j < n; j++) begin
				case (fill)
					FILL_RANDOM: mat[i][j] = rand_value();
					FILL_DIAGONAL, FILL_DIAG_FLAW: mat[i][j] = (i == j) ? rand_value() : '0;
					FILL_CONSTANT: mat[i][j] = v;
					default: mat[i][j] = (j >= i) ? rand_value() : mat[j][i];
				endcase
			end
		end
		if (n > 1) begin
			i = $urandom_range(0, n - 1);
			j = (i + $urandom_range(1, n - 1)) % n;
			if (fill == FILL_SYM_FLAW) begin
				mat[i][j] = mat[i][j] ^ (32'h1 << $urandom_range(0, 31));
			end else if (fill == FILL_DIAG_FLAW) begin
				if (v == 0) begin
					v = 1;
				end
				mat[i][j] = v;
				if ($urandom_range(0, 1) == 1) begin
					mat[j][i] = v;
				end
			end
		end
	endfunction

	task automatic send_element(input element_t value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				elem_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
		end
		elem_ch.valid <= 1'b1;
		elem_ch.element_value <= value;
		do @(posedge clk); while (!elem_ch.ready);
		burst_left--;
		beat_total++;
		@(negedge clk);
	endtask

	task automatic send_matrix(input int n, input fill_e fill);
		fill_matrix(n, fill);
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				send_element(mat[r][c]);
			end
		end
		matrix_total++;
	endtask

	// A size write also abandons any partial matrix, so it waits for the block to go idle.
	task automatic write_size(input size_t value);
		elem_ch.valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		setting_total++;
	endtask

	initial begin : receiver
		rx_mode_e mode;
		int mode_left;
		int hold_left;
		mode = RX_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_left = HoldCycles;
				hold_pending = 1'b0;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 150);
				end
				mode_left--;
				case (mode)
					RX_ALWAYS: result_ch.ready <= 1'b1;
					RX_HALF: result_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
					default: result_ch.ready <= ~result_ch.ready;
				endcase
			end
		end
	end

	initial begin : stimulus
		size_t size_val;
		int n;
		int first_beat;
		int pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		elem_ch.valid = 1'b0;
		elem_ch.element_value = '0;
		burst_left = 0;
		beat_total = 0;
		matrix_total = 0;
		setting_total = 0;
		repeat (ResetCycles) @(negedge clk);
		arst_n = 1'b1;

		// The reset size of one makes every element a complete matrix.
		send_element(32'h8000_0000);
		send_element(32'h7fff_ffff);

		write_size(size_t'(2));
		send_element(1);
		send_element(0);
		send_element(0);
		send_element(-1);
		send_element(0);
		send_element(5);
		send_element(5);
		send_element(0);
		send_element(0);
		send_element(5);
		send_element(6);
		send_element(0);
		send_element(7);
		send_element(0);
		send_element(1);
		send_element(7);

		write_size(size_t'(0));
		send_element(-1);

		// This partial matrix is abandoned by the next size write.
		write_size(size_t'(3));
		send_element(32'h7fff_ffff);
		send_element(32'h8000_0000);

		write_size(size_t'(127));
		send_matrix(MaxSize, FILL_SYMMETRIC);
		write_size(size_t'(64));
		repeat (100) send_element(rand_value());

		first_beat = beat_total;
		while (beat_total - first_beat < RandomItems) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				size_val = size_t'($urandom_range(1, 6));
			end else if (pick < 18) begin
				size_val = size_t'($urandom_range(7, 12));
			end else if (pick == 18) begin
				size_val = '0;
			end else begin
				size_val = size_t'($urandom_range(13, 20));
			end
			write_size(size_val);
			n = (size_val == 0) ? 1 : int'(size_val);
			repeat ($urandom_range(1, 4)) send_matrix(n, fill_e'($urandom_range(0, 5)));
			if (n > 1 && $urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, n*n - 1)) send_element(rand_value());
			end
		end

		// Single-element matrices while the receiver holds off fill the block up.
		write_size(size_t'(1));
		@(posedge clk);
		hold_pending = 1'b1;
		@(negedge clk);
		repeat (PressureItems) send_element(rand_value());

		elem_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		$display("Checked %0d verdicts from %0d element beats over %0d size settings,",
			verdicts_seen, beat_total, setting_total);
		$display("%0d matrices, a clamped 64-by-64 matrix, abandoned matrices and a long hold-off.",
			matrix_total);
		if (fail_count == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
